// File: sv/substring_contains_matcher_core_assert.svh
// Assertion macros shared by the matcher RTL.
`ifndef SUBSTRING_CONTAINS_MATCHER_CORE_ASSERT_SVH
`define SUBSTRING_CONTAINS_MATCHER_CORE_ASSERT_SVH

// Generic form with an explicit clock and active-low reset.
`define SCM_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Common form on the block clock and reset.
`define SCM_ASSERT(label, prop, msg) \
  `SCM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: sv/scm_pkg.sv
// Package with the shared types, constants and functions of the matcher.
package scm_pkg;

  localparam int MaxPattern = 32;
  localparam int IdxW       = $clog2(MaxPattern);
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int ByteW      = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = LenW;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeByte = 2'd1,
    ModeEnd  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegCaseIns = 2'd0,
    RegPatLen  = 2'd1
  } cfg_reg_e;

  // Controls shared by every cell of the row.
  typedef struct packed {
    logic shift;
    logic rotate;
    logic fold;
  } cell_ctrl_t;

  function automatic logic [ByteW-1:0] fold_byte(logic [ByteW-1:0] b, logic en);
    logic [ByteW-1:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: sv/substring_contains_matcher_core.sv
// Top level of the substring matcher: cell row, byte count and result register.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | input     | in_valid_i/in_stall_o | mode, pattern_index, byte_value, last
//   out     | output    | out_valid_o/out_stall_i | found
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while in_stall_o is low; a result appears in the
// output register on the cycle after the word that ends a target.
// Cell k compares pattern byte (k + length) mod 32 against the byte entering
// history cell k, so after a pattern length write the pattern ring rotates one
// cell per cycle and input words stall until it is aligned.
// Reset clears the history, byte count, registers and output; pattern bytes
// are undefined until loaded. Input stalls while a result waits on out_stall_i.
`include "substring_contains_matcher_core_assert.svh"

module substring_contains_matcher_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [scm_pkg::IdxW-1:0]           pattern_index_i,
  input  logic [scm_pkg::ByteW-1:0]          byte_value_i,
  input  logic                               last_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               found_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [scm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [scm_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int Max  = scm_pkg::MaxPattern;
  localparam int IdxW = scm_pkg::IdxW;
  localparam int LenW = scm_pkg::LenW;

  logic                 case_ins_q, case_ins_d;
  logic [LenW-1:0]      pat_len_q, pat_len_d;
  logic [IdxW-1:0]      off_q, off_d;
  logic [LenW-1:0]      seen_q, seen_d;
  logic                 match_q, match_d;
  logic                 out_valid_q, out_valid_d;
  logic                 found_q, found_d;

  logic [LenW-1:0]      len_eff;
  logic [IdxW-1:0]      rot_target;
  logic                 aligned;
  logic                 in_acc;
  logic                 cfg_we;
  scm_pkg::mode_e       mode;
  logic                 is_byte, is_load, is_end, finish;
  logic [LenW-1:0]      seen_inc;
  logic                 win_ok, match_now, match_any;
  logic [IdxW-1:0]      wr_sel;
  scm_pkg::cell_ctrl_t  ctrl;

  logic [scm_pkg::ByteW-1:0] hist [Max];
  logic [scm_pkg::ByteW-1:0] pat  [Max];
  logic [Max-1:0]            hit;
  logic [Max-1:0]            active;
  logic [Max-1:0]            wr_en;

  assign len_eff    = (pat_len_q > LenW'(Max)) ? LenW'(Max) : pat_len_q;
  assign rot_target = len_eff[IdxW-1:0];
  assign aligned    = (off_q == rot_target);

  assign in_stall_o = !aligned || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mode       = scm_pkg::mode_e'(mode_i);

  always_comb begin
    is_byte = 1'b0;
    is_load = 1'b0;
    is_end  = 1'b0;
    unique case (mode)
      scm_pkg::ModeLoad: is_load = in_acc &&
                                   ({1'b0, pattern_index_i} < LenW'(Max));
      scm_pkg::ModeByte: is_byte = in_acc;
      scm_pkg::ModeEnd:  is_end  = in_acc;
      default: ;
    endcase
  end

  assign finish    = is_end || (is_byte && last_byte_i);
  assign seen_inc  = (seen_q == LenW'(Max)) ? seen_q : seen_q + LenW'(1);
  assign win_ok    = (len_eff != '0) && (seen_inc >= len_eff);
  assign match_now = is_byte && win_ok && (&hit);
  assign match_any = match_q || match_now;

  // Cell k holds pattern byte (k + offset) mod depth.
  assign wr_sel = pattern_index_i - off_q;

  assign ctrl.shift  = is_byte;
  assign ctrl.rotate = !aligned;
  assign ctrl.fold   = case_ins_q;

  for (genvar k = 0; k < Max; k++) begin : g_cell
    logic [scm_pkg::ByteW-1:0] hist_in;
    logic [scm_pkg::ByteW-1:0] pat_in;

    if (k == Max - 1) begin : g_head
      assign hist_in = byte_value_i;
      assign pat_in  = pat[0];
    end else begin : g_body
      assign hist_in = hist[k+1];
      assign pat_in  = pat[k+1];
    end

    assign active[k] = LenW'(Max - 1 - k) < len_eff;
    assign wr_en[k]  = is_load && (wr_sel == IdxW'(k));

    scm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .hist_i    (hist_in),
      .hist_o    (hist[k]),
      .pat_i     (pat_in),
      .pat_o     (pat[k]),
      .wr_en_i   (wr_en[k]),
      .wr_byte_i (byte_value_i),
      .active_i  (active[k]),
      .hit_o     (hit[k])
    );
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    case_ins_d = case_ins_q;
    pat_len_d  = pat_len_q;
    if (cfg_we) begin
      unique case (scm_pkg::cfg_reg_e'(cfg_index_i))
        scm_pkg::RegCaseIns: case_ins_d = cfg_data_i[0];
        scm_pkg::RegPatLen:  pat_len_d  = cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    off_d       = aligned ? off_q : off_q + IdxW'(1);
    seen_d      = seen_q;
    match_d     = match_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    if (finish) begin
      seen_d      = '0;
      match_d     = 1'b0;
      out_valid_d = 1'b1;
      found_d     = (len_eff == '0) || match_any;
    end else if (is_byte) begin
      seen_d  = seen_inc;
      match_d = match_any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_ins_q  <= 1'b0;
      pat_len_q   <= '0;
      off_q       <= '0;
      seen_q      <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      case_ins_q  <= case_ins_d;
      pat_len_q   <= pat_len_d;
      off_q       <= off_d;
      seen_q      <= seen_d;
      match_q     <= match_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

  `SCM_ASSERT(a_no_accept_misaligned, !aligned |-> !in_acc, "word accepted during realignment")
  `SCM_ASSERT(a_seen_bounded, seen_q <= LenW'(Max), "byte count above pattern depth")
  `SCM_ASSERT(a_end_clears, finish |=> (seen_q == '0) && !match_q && out_valid_q, "end of target did not clear state")
  `SCM_ASSERT(a_empty_found, (finish && (len_eff == '0)) |=> found_q, "empty pattern not reported as found")
  `SCM_ASSERT(a_rotate_step, !aligned |=> (off_q == $past(off_q) + IdxW'(1)), "pattern ring did not advance")

endmodule

// File: sv/scm_cell.sv
// One matcher cell: a history byte, its aligned pattern byte and a byte compare.
module scm_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  scm_pkg::cell_ctrl_t            ctrl_i,
  input  logic [scm_pkg::ByteW-1:0]      hist_i,
  output logic [scm_pkg::ByteW-1:0]      hist_o,
  input  logic [scm_pkg::ByteW-1:0]      pat_i,
  output logic [scm_pkg::ByteW-1:0]      pat_o,
  input  logic                           wr_en_i,
  input  logic [scm_pkg::ByteW-1:0]      wr_byte_i,
  input  logic                           active_i,
  output logic                           hit_o
);

  logic [scm_pkg::ByteW-1:0] hist_q, hist_d;
  logic [scm_pkg::ByteW-1:0] pat_q;

  assign hist_d = ctrl_i.shift ? hist_i : hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // The pattern byte is either loaded directly or taken from the neighbor
  // while the ring realigns to a new pattern length.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q <= wr_byte_i;
    end else if (ctrl_i.rotate) begin
      pat_q <= pat_i;
    end
  end

  // The compare looks at the byte that enters this cell on the current word.
  assign hit_o = !active_i ||
                 (scm_pkg::fold_byte(hist_i, ctrl_i.fold) ==
                  scm_pkg::fold_byte(pat_q, ctrl_i.fold));

  assign hist_o = hist_q;
  assign pat_o  = pat_q;

endmodule

// File: tb/sv/tb_substring_contains_matcher_core.sv
// Self-checking testbench for the substring matcher core with a found-flag scoreboard.
`timescale 1ns / 100ps

module tb_substring_contains_matcher_core;
  import scm_pkg::*;

  localparam logic [1:0]         ModeSpare    = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpareA    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB    = 2'd3;
  localparam int                 SettleCycles = 40;
  localparam int                 ItemGoal     = 1275;
  localparam int                 PhaseItems   = 100;

  // Tracks pattern, history window and registers, and queues the expected found flags.
  class substring_predictor;
    logic [ByteW-1:0] pat_mem [MaxPattern];
    logic [ByteW-1:0] window [MaxPattern];
    int unsigned      seen;
    bit               hit_seen;
    bit               fold_en;
    logic [LenW-1:0]  len_reg;
    bit               found_q [$];
    int unsigned      errors;

    function new();
      foreach (pat_mem[i]) pat_mem[i] = '0;
      clear_target();
      fold_en = 1'b0;
      len_reg = '0;
      errors  = 0;
    endfunction

    function int unsigned active_len();
      return (len_reg > MaxPattern) ? MaxPattern : len_reg;
    endfunction

    function logic [ByteW-1:0] lower(logic [ByteW-1:0] b);
      if (fold_en && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
      return b;
    endfunction

    function void clear_target();
      foreach (window[i]) window[i] = '0;
      seen     = 0;
      hit_seen = 1'b0;
    endfunction

    function void shift_in(logic [ByteW-1:0] b);
      int unsigned n;
      bit same;
      for (int k = 0; k < MaxPattern - 1; k++) window[k] = window[k+1];
      window[MaxPattern-1] = b;
      if (seen < MaxPattern) seen++;
      n = active_len();
      if (n == 0 || seen < n) return;
      same = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (lower(pat_mem[k]) != lower(window[MaxPattern-n+k])) same = 1'b0;
      end
      if (same) hit_seen = 1'b1;
    endfunction

    function void close_target();
      found_q.push_back(active_len() == 0 || hit_seen);
      clear_target();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegCaseIns: fold_en = data[0];
        RegPatLen:  len_reg = data;
        default: ;
      endcase
    endfunction

    function void note_word(logic [1:0] mode, logic [IdxW-1:0] idx, logic [ByteW-1:0] b,
                            logic last);
      case (mode)
        ModeLoad: pat_mem[idx] = b;
        ModeByte: begin
          shift_in(b);
          if (last) close_target();
        end
        ModeEnd: close_target();
        default: ;
      endcase
    endfunction

    function void check_found(logic actual);
      bit want;
      if (found_q.size() == 0) begin
        $error("found: expected no word, actual %0b", actual);
        errors++;
        return;
      end
      want = found_q.pop_front();
      if (actual !== want) begin
        $error("found: expected %0b, actual %0b", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return found_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i          = '0;
  logic [IdxW-1:0]    pattern_index_i = '0;
  logic [ByteW-1:0]   byte_value_i    = '0;
  logic               last_byte_i     = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic               found_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;

  substring_predictor pred = new();

  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          hold_left  = 0;
  int          items_sent = 0;
  int unsigned active_len = 0;

  substring_contains_matcher_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .pattern_index_i (pattern_index_i),
    .byte_value_i    (byte_value_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A requested hold keeps the output stalled long enough for the block to back up.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) pred.check_found(found_o);
  end

  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)
      return ByteW'(8'h41 + $urandom_range(25) + ($urandom_range(1) ? 8'h20 : 8'h00));
    if (r < 55) begin
      case ($urandom_range(5))
        0: return 8'h40;
        1: return 8'h5B;
        2: return 8'h60;
        3: return 8'h7B;
        4: return 8'h00;
        default: return 8'hFF;
      endcase
    end
    return ByteW'($urandom_range(255));
  endfunction

  // Letters change case often when folding is on, rarely otherwise.
  function automatic logic [ByteW-1:0] flip_case(logic [ByteW-1:0] b);
    bit letter;
    letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    if (letter && $urandom_range(99) < (pred.fold_en ? 50 : 10)) return b ^ 8'h20;
    return b;
  endfunction

  task automatic send_word(logic [1:0] mode, logic [IdxW-1:0] idx, logic [ByteW-1:0] b,
                           logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    mode_i          = mode;
    pattern_index_i = idx;
    byte_value_i    = b;
    last_byte_i     = last;
    do @(posedge clk_i); while (in_stall_o);
    pred.note_word(mode, idx, b, last);
    if (mode != ModeSpare) items_sent++;
  endtask

  task automatic send_load(logic [IdxW-1:0] idx, logic [ByteW-1:0] b);
    send_word(ModeLoad, idx, b, 1'($urandom_range(1)));
  endtask

  task automatic send_byte(logic [ByteW-1:0] b, logic last);
    send_word(ModeByte, IdxW'($urandom), b, last);
  endtask

  task automatic send_end();
    send_word(ModeEnd, IdxW'($urandom), ByteW'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic send_spare();
    send_word(ModeSpare, IdxW'($urandom), ByteW'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic noise_word();
    case ($urandom_range(2))
      0: send_spare();
      1: send_load(IdxW'($urandom), pick_byte());
      default: send_end();
    endcase
  endtask

  // Registers change only once every found flag is back and the block has settled.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    pred.set_reg(idx, data);
    if (idx == RegPatLen) active_len = (data > MaxPattern) ? MaxPattern : data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random target, often with the pattern planted in it, sometimes with one byte spoiled.
  task automatic send_target();
    logic [ByteW-1:0] tgt [$];
    int n;
    int pos;
    bit by_end;
    n = ($urandom_range(19) == 0) ? $urandom_range(90) : $urandom_range(active_len + 8);
    for (int i = 0; i < n; i++) begin
      if (active_len > 0 && $urandom_range(1))
        tgt.push_back(flip_case(pred.pat_mem[$urandom_range(active_len - 1)]));
      else
        tgt.push_back(pick_byte());
    end
    if (active_len > 0 && n >= active_len && $urandom_range(99) < 60) begin
      pos = $urandom_range(n - active_len);
      for (int i = 0; i < active_len; i++) tgt[pos+i] = flip_case(pred.pat_mem[i]);
      if ($urandom_range(4) == 0) tgt[pos + $urandom_range(active_len - 1)] = pick_byte();
    end
    by_end = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(39) == 0) noise_word();
      send_byte(tgt[i], !by_end && i == n - 1);
    end
    if (by_end) send_end();
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int new_len;
    int start;
    logic [CfgDataW-1:0] cfg;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pattern matches an empty target and any other target.
    send_end();
    send_spare();
    send_byte(8'hFF, 1'b1);
    send_load(5'd0, 8'h5A);
    send_load(5'd1, 8'h5B);
    send_load(5'd2, 8'h61);
    send_load(5'd31, 8'hFF);
    write_reg(RegPatLen, 6'd3);
    write_reg(RegCaseIns, 6'd0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h61, 1'b1);
    // Target shorter than the pattern.
    send_byte(8'h7A, 1'b0);
    send_byte(8'h5B, 1'b1);
    // Case differs while folding is off, closed by an end word.
    send_byte(8'h7A, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h41, 1'b0);
    send_end();
    write_reg(RegCaseIns, 6'h3F);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h41, 1'b1);
    // Pattern length shrinks in the middle of a target.
    send_byte(8'h78, 1'b0);
    send_byte(8'h5A, 1'b0);
    write_reg(RegPatLen, 6'd2);
    send_byte(8'h5B, 1'b1);
    send_end();
    write_reg(RegSpareA, CfgDataW'($urandom));
    write_reg(RegSpareB, CfgDataW'($urandom));

    for (int ph = 0; items_sent < ItemGoal; ph++) begin
      case (ph)
        0: new_len = 1;
        1: new_len = 32;
        2: new_len = 63;
        3: new_len = 0;
        4: new_len = 33;
        default: begin
          case ($urandom_range(9))
            7, 8:    new_len = $urandom_range(32, 9);
            9:       new_len = $urandom_range(63, 33);
            default: new_len = $urandom_range(8, 1);
          endcase
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int i = 0; i < ((new_len > MaxPattern) ? MaxPattern : new_len); i++)
        send_load(IdxW'(i), pick_byte());
      cfg    = CfgDataW'($urandom);
      cfg[0] = (ph < 2) ? ph[0] : 1'($urandom_range(1));
      write_reg(RegCaseIns, cfg);
      write_reg(RegPatLen, CfgDataW'(new_len));
      if (ph == 2 || ph == 7) hold_left = 400;
      start = items_sent;
      while (items_sent - start < PhaseItems) send_target();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pred.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
